FILE: hw/rtl/sfd_pkg.sv
// Shared types and constants for the sample frame deframer.
// No dependencies; sample_frame_deframer and sfd_out import this package, sfd_ring does not.
package sfd_pkg;

	localparam logic [7:0] HEADER_FIRST_RST = 8'h5A;
	localparam logic [7:0] HEADER_SECOND_RST = 8'h5A;
	localparam logic [7:0] TAIL_FIRST_RST = 8'hA5;
	localparam logic [7:0] TAIL_SECOND_RST = 8'hA5;

	// Configuration register indexes.
	localparam logic [7:0] REG_HEADER_FIRST = 8'd0;
	localparam logic [7:0] REG_HEADER_SECOND = 8'd1;
	localparam logic [7:0] REG_TAIL_FIRST = 8'd2;
	localparam logic [7:0] REG_TAIL_SECOND = 8'd3;

	// Frame type codes and the largest legal type or width code.
	localparam logic [1:0] FT_ADC = 2'd1;
	localparam logic [1:0] FT_EVENT = 2'd3;
	localparam logic [7:0] CODE_MAX = 8'd3;

	// Byte offset of the first sample byte inside a frame.
	localparam int unsigned DATA_OFFSET = 6;
	// Header, counter, type, width, count and two tail bytes.
	localparam int unsigned FRAME_OVERHEAD = 8;
	// Results beyond this count for one received word are dropped.
	localparam logic [6:0] RESULT_CAP = 7'd64;

	typedef enum logic [1:0] {
		KIND_ADC = 2'd0,
		KIND_EVENT = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_TAIL_ERR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HDR2,
		PH_COUNTER,
		PH_TYPE,
		PH_WIDTH,
		PH_CHANS,
		PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FEED,
		ST_SREAD,
		ST_SACC,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		kind_t kind;
		logic [2:0] chan_index;
		logic [23:0] sample_value;
		logic [7:0] event_code;
		logic seq_gap;
	} result_t;

	typedef struct packed {
		logic room;
		logic hold_v;
		logic out_free;
	} out_stat_t;

endpackage

FILE: hw/rtl/sample_frame_deframer.sv
// Sample frame deframer: takes one received byte per input word and finds
// frames of header, sequence counter, type, sample width, channel count,
// big-endian samples and two tail bytes. Every byte is stored in a ring and
// parsed by one byte-wide compare and accumulate unit under a small sequencer,
// so the input is not ready while a byte is worked on. A byte that causes no
// result goes through accept, ring read, parse, a second ring check that
// finds nothing left to parse, and the end of the step. A byte that ends
// an ADC frame adds a ring read and an accumulate step per sample byte,
// since every sample byte is read back through the single ring read port.
// A rejected field or a tail mismatch restarts the header search at the byte
// after the header start and replays it, reading and parsing each byte again.
// Results leave through a hold stage and an output register; the last word of
// a step carries last, and a stalled output holds the sequencer only when a
// new result is due or when the final word of a step must move into the
// output register. No clearing pass follows reset.
module sample_frame_deframer
	import sfd_pkg::*;
#(
	parameter int unsigned MAX_CHANNELS = 8,
	parameter int unsigned FRAME_BYTES = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [2:0] chan_index,
	output logic [23:0] sample_value,
	output logic [7:0] event_code,
	output logic seq_gap,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_index,
	input logic [7:0] cfg_data
);

	// Ring pointers span twice the frame size, enough for one frame plus replay.
	localparam int unsigned PW = $clog2(FRAME_BYTES) + 1;
	localparam int unsigned FW = $clog2(FRAME_BYTES + 1);
	localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);

	// Configuration registers.
	logic [7:0] hdr_first_q, hdr_second_q, tail_first_q, tail_second_q;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic [PW-1:0] head_q, head_d, rd_q, rd_d, wr_q, sp_q, sp_d;
	logic [FW-1:0] fill_q, fill_d, total_q, total_d;
	logic [7:0] prev_cnt_q, prev_cnt_d, held_q, held_d;
	logic [7:0] prev_b_q, prev_b_d, first_q, first_d;
	logic [1:0] type_q, type_d, width_q, width_d, k_q, k_d;
	logic [CW-1:0] chans_q, chans_d, c_q, c_d;
	logic gap_q, gap_d;
	logic [23:0] v_q, v_d;
	logic [6:0] cnt_q, cnt_d;

	logic in_acc;
	logic ring_rd_en;
	logic [PW-1:0] ring_rd_addr;
	logic [7:0] b;
	logic push, flush, push_room;
	result_t push_res, out_res;
	out_stat_t ostat;

	logic [FW-1:0] fill_inc;
	logic [10:0] len;
	logic at_end, tail_ok, adc_samples, need_emit;
	logic [23:0] v_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q <= HEADER_FIRST_RST;
			hdr_second_q <= HEADER_SECOND_RST;
			tail_first_q <= TAIL_FIRST_RST;
			tail_second_q <= TAIL_SECOND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER_FIRST: hdr_first_q <= cfg_data;
				REG_HEADER_SECOND: hdr_second_q <= cfg_data;
				REG_TAIL_FIRST: tail_first_q <= cfg_data;
				REG_TAIL_SECOND: tail_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;

	sfd_ring #(.AW(PW)) u_ring (
		.clk(clk),
		.wr_en(in_acc),
		.wr_addr(wr_q),
		.wr_data(rx_byte),
		.rd_en(ring_rd_en),
		.rd_addr(ring_rd_addr),
		.rd_data(b)
	);

	// A dropped result above the cap still counts as delivered.
	assign push_room = ostat.room || (cnt_q >= RESULT_CAP);

	// Byte checks of the parse step, shared by every phase.
	assign fill_inc = fill_q + FW'(1);
	assign len = 11'(FRAME_OVERHEAD) + ({9'd0, width_q} * {3'd0, b});
	assign at_end = (phase_q == PH_DATA) && (fill_inc >= total_q);
	assign tail_ok = (prev_b_q == tail_first_q) && (b == tail_second_q);
	assign adc_samples = (type_q == FT_ADC) && (chans_q != '0);
	assign need_emit = at_end && !(tail_ok && adc_samples);
	assign v_n = (k_q == 2'd0) ? {16'd0, b} : {v_q[15:0], b};

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		head_d = head_q;
		rd_d = rd_q;
		sp_d = sp_q;
		fill_d = fill_q;
		total_d = total_q;
		prev_cnt_d = prev_cnt_q;
		held_d = held_q;
		prev_b_d = prev_b_q;
		first_d = first_q;
		type_d = type_q;
		width_d = width_q;
		chans_d = chans_q;
		c_d = c_q;
		k_d = k_q;
		gap_d = gap_q;
		v_d = v_q;
		cnt_d = cnt_q;
		ring_rd_en = 1'b0;
		ring_rd_addr = rd_q;
		push = 1'b0;
		flush = 1'b0;
		push_res = '{kind: KIND_EMPTY, chan_index: 3'd0, sample_value: 24'd0,
			event_code: held_q, seq_gap: gap_q};

		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cnt_d = '0;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (rd_q == wr_q) begin
					state_d = ST_FLUSH;
				end else begin
					ring_rd_en = 1'b1;
					state_d = ST_FEED;
				end
			end
			ST_FEED: begin
				if (!(need_emit && !push_room)) begin
					rd_d = rd_q + PW'(1);
					prev_b_d = b;
					state_d = ST_READ;
					if (phase_q == PH_HUNT) begin
						if (b == hdr_first_q) begin
							head_d = rd_q;
							fill_d = FW'(1);
							phase_d = PH_HDR2;
						end
					end else begin
						fill_d = fill_inc;
						unique case (phase_q)
							PH_HDR2: begin
								if (b == hdr_second_q) begin
									phase_d = PH_COUNTER;
								end else begin
									phase_d = PH_HUNT;
								end
							end
							PH_COUNTER: begin
								gap_d = (b != prev_cnt_q + 8'd1);
								prev_cnt_d = b;
								phase_d = PH_TYPE;
							end
							PH_TYPE: begin
								if (b != 8'd0 && b <= CODE_MAX) begin
									type_d = b[1:0];
									phase_d = PH_WIDTH;
								end else begin
									type_d = 2'd0;
									phase_d = PH_HUNT;
								end
							end
							PH_WIDTH: begin
								if (b != 8'd0 && b <= CODE_MAX) begin
									width_d = b[1:0];
									phase_d = PH_CHANS;
								end else begin
									width_d = 2'd0;
									phase_d = PH_HUNT;
								end
							end
							PH_CHANS: begin
								if (b <= 8'(MAX_CHANNELS) && len <= 11'(FRAME_BYTES)) begin
									chans_d = CW'(b);
									total_d = FW'(len);
									phase_d = PH_DATA;
								end else begin
									chans_d = '0;
									phase_d = PH_HUNT;
								end
							end
							default: begin
								if (fill_q == FW'(DATA_OFFSET)) begin
									first_d = b;
								end
								if (at_end) begin
									phase_d = PH_HUNT;
									if (!tail_ok) begin
										push_res.kind = KIND_TAIL_ERR;
									end else if (adc_samples) begin
										sp_d = head_q + PW'(DATA_OFFSET);
										c_d = '0;
										k_d = 2'd0;
										state_d = ST_SREAD;
									end else if (type_q == FT_EVENT && chans_q != '0) begin
										held_d = (fill_q == FW'(DATA_OFFSET)) ? b : first_q;
										push_res.kind = KIND_EVENT;
										push_res.event_code = held_d;
									end
									if (need_emit) begin
										push = (cnt_q < RESULT_CAP);
										cnt_d = cnt_q + 7'd1;
									end
								end
							end
						endcase
						if (phase_d == PH_HUNT) begin
							fill_d = '0;
							// Tail mismatch and rejected fields replay from the byte after the header start.
							if (!(at_end && tail_ok)) begin
								rd_d = head_q + PW'(1);
							end
						end
					end
				end
			end
			ST_SREAD: begin
				ring_rd_en = 1'b1;
				ring_rd_addr = sp_q;
				state_d = ST_SACC;
			end
			ST_SACC: begin
				if (k_q == width_q - 2'd1) begin
					if (push_room) begin
						push = (cnt_q < RESULT_CAP);
						cnt_d = cnt_q + 7'd1;
						push_res.kind = KIND_ADC;
						push_res.chan_index = 3'(c_q);
						push_res.sample_value = v_n;
						sp_d = sp_q + PW'(1);
						v_d = v_n;
						k_d = 2'd0;
						if (c_q + CW'(1) == chans_q) begin
							state_d = ST_READ;
						end else begin
							c_d = c_q + CW'(1);
							state_d = ST_SREAD;
						end
					end
				end else begin
					v_d = v_n;
					k_d = k_q + 2'd1;
					sp_d = sp_q + PW'(1);
					state_d = ST_SREAD;
				end
			end
			default: begin
				// End of step: the held result goes out marked last.
				if (!ostat.hold_v) begin
					state_d = ST_IDLE;
				end else if (ostat.out_free) begin
					flush = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_HUNT;
			head_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			sp_q <= '0;
			fill_q <= '0;
			total_q <= FW'(FRAME_OVERHEAD);
			prev_cnt_q <= '0;
			held_q <= '0;
			type_q <= '0;
			width_q <= '0;
			chans_q <= '0;
			c_q <= '0;
			k_q <= '0;
			gap_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			head_q <= head_d;
			rd_q <= rd_d;
			if (in_acc) begin
				wr_q <= wr_q + PW'(1);
			end
			sp_q <= sp_d;
			fill_q <= fill_d;
			total_q <= total_d;
			prev_cnt_q <= prev_cnt_d;
			held_q <= held_d;
			type_q <= type_d;
			width_q <= width_d;
			chans_q <= chans_d;
			c_q <= c_d;
			k_q <= k_d;
			gap_q <= gap_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		prev_b_q <= prev_b_d;
		first_q <= first_d;
		v_q <= v_d;
	end

	sfd_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_res(push_res),
		.flush(flush),
		.stat(ostat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res(out_res),
		.out_last(last)
	);

	assign kind = out_res.kind;
	assign chan_index = out_res.chan_index;
	assign sample_value = out_res.sample_value;
	assign event_code = out_res.event_code;
	assign seq_gap = out_res.seq_gap;

	// Between words every result of the step has left the hold stage.
	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ostat.hold_v)
		else $error("result still held while idle");

	// Between words the replay queue is empty.
	a_idle_queue_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> rd_q == wr_q)
		else $error("unparsed bytes left while idle");

	// The frame never grows past its limit.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(FRAME_BYTES))
		else $error("frame fill beyond frame size");

	// A push never meets a full hold stage and output register.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ostat.room)
		else $error("result pushed without room");

endmodule

FILE: hw/rtl/sfd_ring.sv
// Byte ring that holds the received stream from the current frame start on.
// Depends on nothing; one write port, one read port with registered data.
module sfd_ring #(
	parameter int unsigned AW = 6
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input logic [7:0] wr_data,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output logic [7:0] rd_data
);

	logic [7:0] mem_q [2**AW];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/sfd_out.sv
// Result hold stage and output register of the deframer.
// Depends on sfd_pkg; the hold stage lets the final word of a step carry last.
module sfd_out
	import sfd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input result_t push_res,
	input logic flush,
	output out_stat_t stat,
	output logic out_valid,
	input logic out_ready,
	output result_t out_res,
	output logic out_last
);

	logic hold_v_q;
	result_t hold_q;
	logic out_v_q;
	result_t out_q;
	logic last_q;
	logic out_free;

	assign out_free = !out_v_q || out_ready;
	assign stat = '{room: !hold_v_q || out_free, hold_v: hold_v_q, out_free: out_free};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (push) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) begin
					out_v_q <= 1'b1;
				end else if (out_ready) begin
					out_v_q <= 1'b0;
				end
			end else if (flush && hold_v_q && out_free) begin
				hold_v_q <= 1'b0;
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hold_q <= push_res;
			if (hold_v_q) begin
				out_q <= hold_q;
				last_q <= 1'b0;
			end
		end else if (flush && hold_v_q && out_free) begin
			out_q <= hold_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid = out_v_q;
	assign out_res = out_q;
	assign out_last = last_q;

endmodule
